### hw/rtl/packed_stamp_seconds_difference_unit_defines.svh
// Assertion macros for the packed stamp seconds difference unit.
// Each macro expects signals named clk and rst in the scope of use.
`ifndef PACKED_STAMP_SECONDS_DIFFERENCE_UNIT_DEFINES_SVH
`define PACKED_STAMP_SECONDS_DIFFERENCE_UNIT_DEFINES_SVH

`ifndef SYNTHESIS
`define PSD_ASSERT(lbl, prop) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) \
    else $error("psd: assertion failed");
`define PSD_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("psd: assertion failed");
`else
`define PSD_ASSERT(lbl, prop)
`define PSD_ASSERT_NEXT(lbl, ante, cons)
`endif

`endif

### hw/rtl/psd_pkg.sv
`default_nettype none

package psd_pkg;

  // Pipeline depth: stages inside one stamp decoder, plus the output stage.
  localparam int DEC_STAGES = 11;
  localparam int NSTAGE     = DEC_STAGES + 1;

  // Constant dividers and their reciprocal estimates. Each estimate is
  // floor(2^SH / DIV) and undershoots the true quotient by at most one.
  localparam logic [31:0] DIV_Y = 32'd100000000;
  localparam logic [37:0] REC_Y = 38'd42;        // shift 32
  localparam logic [26:0] DIV_M = 27'd1000000;
  localparam logic [35:0] REC_M = 36'd134;       // shift 27
  localparam logic [19:0] DIV_D = 20'd10000;
  localparam logic [26:0] REC_D = 27'd104;       // shift 20
  localparam logic [13:0] DIV_H = 14'd100;
  localparam logic [21:0] REC_H = 22'd163;       // shift 14

  localparam logic [14:0] DAYS_TO_2000 = 15'd7305;  // 1980-01-01 to 2000-01-01
  localparam logic [31:0] SECS_PER_DAY = 32'd86400;

  // Years 2000..2042 only: divisible by four means leap (2000 is a leap year).
  function automatic logic is_leap(input logic [5:0] yoff);
    return (yoff[1:0] == 2'd0);
  endfunction

  // Days from 1980-01-01 to the first day of year 2000 + yoff.
  function automatic logic [14:0] year_days(input logic [5:0] yoff);
    logic [14:0] lp;
    lp = 15'((7'(yoff) + 7'd3) >> 2);
    return DAYS_TO_2000 + 15'(yoff) * 15'd365 + lp;
  endfunction

  function automatic logic [4:0] month_len(input logic [3:0] m, input logic leap);
    logic [4:0] len;
    case (m)
      4'd2:                      len = leap ? 5'd29 : 5'd28;
      4'd4, 4'd6, 4'd9, 4'd11:   len = 5'd30;
      default:                   len = 5'd31;
    endcase
    return len;
  endfunction

  // Days in the year before the first of month m.
  function automatic logic [8:0] month_cum(input logic [3:0] m, input logic leap);
    logic [8:0] c;
    case (m)
      4'd1:    c = 9'd0;
      4'd2:    c = 9'd31;
      4'd3:    c = 9'd59;
      4'd4:    c = 9'd90;
      4'd5:    c = 9'd120;
      4'd6:    c = 9'd151;
      4'd7:    c = 9'd181;
      4'd8:    c = 9'd212;
      4'd9:    c = 9'd243;
      4'd10:   c = 9'd273;
      4'd11:   c = 9'd304;
      4'd12:   c = 9'd334;
      default: c = 9'd0;
    endcase
    if (leap && (m > 4'd2)) begin
      c = c + 9'd1;
    end
    return c;
  endfunction

endpackage

`default_nettype wire

### hw/rtl/psd_ifs.sv
`default_nettype none

// Input channel: one pair of packed stamps per transfer.
interface psd_in_if;
  logic        valid;
  logic        ready;
  logic [31:0] stamp_first;
  logic [31:0] stamp_second;

  modport source (output valid, output stamp_first, output stamp_second, input ready);
  modport sink   (input valid, input stamp_first, input stamp_second, output ready);
endinterface

// Output channel: one difference per transfer.
interface psd_out_if;
  logic        valid;
  logic        ready;
  logic [31:0] difference_seconds;
  logic        dates_valid;

  modport source (output valid, output difference_seconds, output dates_valid,
                  input ready);
  modport sink   (input valid, input difference_seconds, input dates_valid,
                  output ready);
endinterface

`default_nettype wire

### hw/rtl/psd_stamp_decode.sv
`default_nettype none

// Pipelined decode of one packed YYMMDDhhmm stamp into seconds since 1980.
// Payload only; stage enables come from the valid chain in the top level.
module psd_stamp_decode (
  input  wire logic                            clk,
  input  wire logic [psd_pkg::DEC_STAGES-1:0]  en,
  input  wire logic [31:0]                     stamp,
  output logic      [31:0]                     secs,
  output logic                                 ok
);

  // stage 1: year quotient estimate
  logic [31:0] s1_v;
  logic [5:0]  s1_q;
  // stage 2: year corrected, remainder below 10^8
  logic [5:0]  s2_y;
  logic [26:0] s2_r;
  // stage 3: month estimate, year day count
  logic [5:0]  s3_y;
  logic [14:0] s3_yd;
  logic [26:0] s3_r;
  logic [6:0]  s3_q;
  // stage 4: month corrected
  logic [5:0]  s4_y;
  logic [14:0] s4_yd;
  logic [6:0]  s4_mo;
  logic [19:0] s4_r;
  // stage 5: day estimate
  logic [5:0]  s5_y;
  logic [14:0] s5_yd;
  logic [6:0]  s5_mo;
  logic [19:0] s5_r;
  logic [6:0]  s5_q;
  // stage 6: day corrected
  logic [5:0]  s6_y;
  logic [14:0] s6_yd;
  logic [6:0]  s6_mo;
  logic [6:0]  s6_dy;
  logic [13:0] s6_r;
  // stage 7: hour estimate
  logic [5:0]  s7_y;
  logic [14:0] s7_yd;
  logic [6:0]  s7_mo;
  logic [6:0]  s7_dy;
  logic [13:0] s7_r;
  logic [6:0]  s7_q;
  // stage 8: hour and minute
  logic [5:0]  s8_y;
  logic [14:0] s8_yd;
  logic [6:0]  s8_mo;
  logic [6:0]  s8_dy;
  logic [6:0]  s8_hr;
  logic [6:0]  s8_mi;
  // stage 9: checks and day count
  logic        s9_ok;
  logic [14:0] s9_days;
  logic [4:0]  s9_hr;
  logic [5:0]  s9_mi;
  // stage 10: products
  logic        s10_ok;
  logic [31:0] s10_ds;
  logic [16:0] s10_hm;
  // stage 11: sum
  logic        s11_ok;
  logic [31:0] s11_secs;

  logic [37:0] y_p;
  logic [31:0] y_rem;
  logic [35:0] m_p;
  logic [26:0] m_rem;
  logic [26:0] d_p;
  logic [19:0] d_rem;
  logic [21:0] h_p;
  logic [13:0] h_rem;
  logic        leap8;
  logic [4:0]  mlen8;
  logic        fields_ok;

  always_comb begin
    y_p   = {6'd0, stamp} * psd_pkg::REC_Y;
    y_rem = s1_v - 32'(s1_q) * psd_pkg::DIV_Y;
    m_p   = {9'd0, s2_r} * psd_pkg::REC_M;
    m_rem = s3_r - 27'(s3_q) * psd_pkg::DIV_M;
    d_p   = {7'd0, s4_r} * psd_pkg::REC_D;
    d_rem = s5_r - 20'(s5_q) * psd_pkg::DIV_D;
    h_p   = {8'd0, s6_r} * psd_pkg::REC_H;
    h_rem = s7_r - 14'(s7_q) * psd_pkg::DIV_H;
    leap8 = psd_pkg::is_leap(s8_y);
    mlen8 = psd_pkg::month_len(s8_mo[3:0], leap8);
    fields_ok = (s8_mo inside {[7'd1:7'd12]}) && (s8_dy != 7'd0) &&
                (s8_dy <= 7'(mlen8)) && (s8_hr <= 7'd23) && (s8_mi <= 7'd59);
  end

  always_ff @(posedge clk) begin
    if (en[0]) begin
      s1_v <= stamp;
      s1_q <= y_p[37:32];
    end
    if (en[1]) begin
      if (y_rem >= psd_pkg::DIV_Y) begin
        s2_y <= s1_q + 6'd1;
        s2_r <= 27'(y_rem - psd_pkg::DIV_Y);
      end else begin
        s2_y <= s1_q;
        s2_r <= y_rem[26:0];
      end
    end
    if (en[2]) begin
      s3_y  <= s2_y;
      s3_yd <= psd_pkg::year_days(s2_y);
      s3_r  <= s2_r;
      s3_q  <= m_p[33:27];
    end
    if (en[3]) begin
      s4_y  <= s3_y;
      s4_yd <= s3_yd;
      if (m_rem >= psd_pkg::DIV_M) begin
        s4_mo <= s3_q + 7'd1;
        s4_r  <= 20'(m_rem - psd_pkg::DIV_M);
      end else begin
        s4_mo <= s3_q;
        s4_r  <= m_rem[19:0];
      end
    end
    if (en[4]) begin
      s5_y  <= s4_y;
      s5_yd <= s4_yd;
      s5_mo <= s4_mo;
      s5_r  <= s4_r;
      s5_q  <= d_p[26:20];
    end
    if (en[5]) begin
      s6_y  <= s5_y;
      s6_yd <= s5_yd;
      s6_mo <= s5_mo;
      if (d_rem >= psd_pkg::DIV_D) begin
        s6_dy <= s5_q + 7'd1;
        s6_r  <= 14'(d_rem - psd_pkg::DIV_D);
      end else begin
        s6_dy <= s5_q;
        s6_r  <= d_rem[13:0];
      end
    end
    if (en[6]) begin
      s7_y  <= s6_y;
      s7_yd <= s6_yd;
      s7_mo <= s6_mo;
      s7_dy <= s6_dy;
      s7_r  <= s6_r;
      s7_q  <= h_p[20:14];
    end
    if (en[7]) begin
      s8_y  <= s7_y;
      s8_yd <= s7_yd;
      s8_mo <= s7_mo;
      s8_dy <= s7_dy;
      if (h_rem >= psd_pkg::DIV_H) begin
        s8_hr <= s7_q + 7'd1;
        s8_mi <= 7'(h_rem - psd_pkg::DIV_H);
      end else begin
        s8_hr <= s7_q;
        s8_mi <= h_rem[6:0];
      end
    end
    if (en[8]) begin
      // day count is meaningless when a field is illegal; ok masks it later
      s9_ok   <= fields_ok;
      s9_days <= s8_yd + 15'(psd_pkg::month_cum(s8_mo[3:0], leap8)) + 15'(s8_dy) - 15'd1;
      s9_hr   <= s8_hr[4:0];
      s9_mi   <= s8_mi[5:0];
    end
    if (en[9]) begin
      s10_ok <= s9_ok;
      s10_ds <= 32'(s9_days) * psd_pkg::SECS_PER_DAY;
      s10_hm <= 17'(s9_hr) * 17'd3600 + 17'(s9_mi) * 17'd60;
    end
    if (en[10]) begin
      s11_ok   <= s10_ok;
      s11_secs <= s10_ds + 32'(s10_hm);
    end
  end

  assign secs = s11_secs;
  assign ok   = s11_ok;

endmodule

`default_nettype wire

### hw/rtl/packed_stamp_seconds_difference_unit.sv
// Channel   Dir  Payload                                  Handshake
// stamps    in   stamp_first[31:0], stamp_second[31:0]    valid / ready
// result    out  difference_seconds[31:0], dates_valid    valid / ready
//
// Throughput: one stamp pair per cycle while the output is not stalled,
// through a 12-stage pipeline (four reciprocal divisions of two stages each,
// calendar check, product, sum, difference). Reset (rst, synchronous)
// empties every stage.
// A stalled output holds its stage; upstream stages keep filling bubbles,
// so stamps.ready stays high until every stage holds an item.
`default_nettype none

`include "packed_stamp_seconds_difference_unit_defines.svh"

module packed_stamp_seconds_difference_unit (
  input  wire logic clk,
  input  wire logic rst,
  psd_in_if.sink    stamps,
  psd_out_if.source result
);

  localparam int NS  = psd_pkg::NSTAGE;
  localparam int DEC = psd_pkg::DEC_STAGES;

  // One valid bit per stage; the last stage is the output register.
  logic [NS-1:0] vld;
  logic [NS-1:0] en;

  logic [31:0] secs_first;
  logic [31:0] secs_second;
  logic        ok_first;
  logic        ok_second;

  logic [31:0] diff;
  logic        both_ok;

  // Stage k advances when it is empty or when stage k+1 advances.
  always_comb begin
    en[NS-1] = !vld[NS-1] || result.ready;
    for (int k = NS - 2; k >= 0; k--) begin
      en[k] = !vld[k] || en[k+1];
    end
  end

  assign stamps.ready = en[0];

  // Valid chain: advance with the enables, hold on stall, drop on reset.
  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else begin
      if (en[0]) begin
        vld[0] <= stamps.valid;
      end
      for (int k = 1; k < NS; k++) begin
        if (en[k]) begin
          vld[k] <= vld[k-1];
        end
      end
    end
  end

  // Both stamps run through identical decoders in lock step.
  psd_stamp_decode u_dec_first (
    .clk   (clk),
    .en    (en[DEC-1:0]),
    .stamp (stamps.stamp_first),
    .secs  (secs_first),
    .ok    (ok_first)
  );

  psd_stamp_decode u_dec_second (
    .clk   (clk),
    .en    (en[DEC-1:0]),
    .stamp (stamps.stamp_second),
    .secs  (secs_second),
    .ok    (ok_second)
  );

  // Output stage: wrap the difference modulo 2^32, clear it on any bad field.
  always_ff @(posedge clk) begin
    if (en[NS-1]) begin
      both_ok <= ok_first && ok_second;
      diff    <= (ok_first && ok_second) ? (secs_second - secs_first) : 32'd0;
    end
  end

  assign result.valid              = vld[NS-1];
  assign result.difference_seconds = diff;
  assign result.dates_valid        = both_ok;

  // An accepted pair lands in the first stage.
  `PSD_ASSERT_NEXT(a_accept_lands, stamps.valid && stamps.ready, vld[0])
  // An empty first stage can always take a transfer.
  `PSD_ASSERT(a_empty_ready, !vld[0] |-> stamps.ready)
  // A full pipe behind a stalled output must refuse input.
  `PSD_ASSERT(a_full_stall, ((&vld) && !result.ready) |-> !stamps.ready)
  // Invalid dates always report zero.
  `PSD_ASSERT(a_bad_zero, (result.valid && !result.dates_valid) |->
                          (result.difference_seconds == 32'd0))

endmodule

`default_nettype wire

### tb/sv/tb_packed_stamp_seconds_difference_unit.sv
`timescale 1ns / 100ps

module tb_packed_stamp_seconds_difference_unit;

  // One stamp pair as it crosses the input channel.
  typedef struct packed {
    logic [31:0] first;
    logic [31:0] second;
  } stamp_pair_t;

  // One predicted answer: wrapped difference and the legality flag.
  typedef struct packed {
    logic [31:0] seconds;
    logic        legal;
  } span_t;

  // Ways to spoil an otherwise legal stamp.
  typedef enum int unsigned {
    BREAK_MONTH,
    BREAK_DAY,
    BREAK_HOUR,
    BREAK_MINUTE
  } field_fault_t;

  localparam int unsigned RANDOM_PAIRS = 1550;
  localparam int unsigned TAIL_CYCLES  = 24;

  logic clk = 1'b0;
  logic rst = 1'b1;

  psd_in_if  stamps_ch ();
  psd_out_if result_ch ();

  packed_stamp_seconds_difference_unit dut (
    .clk    (clk),
    .rst    (rst),
    .stamps (stamps_ch),
    .result (result_ch)
  );

  stamp_pair_t pending_pairs[$];
  span_t       expected_spans[$];

  int unsigned total_pairs;
  int unsigned accepted_pairs;
  int unsigned checked_spans;
  int unsigned legal_spans;
  int unsigned error_count;

  // Sender burst shaping.
  int unsigned burst_left;
  int unsigned gap_left;

  // Receiver stall pattern: a 32-bit word of ready bits, redrawn once all its bits are used.
  logic [31:0] ready_word = '1;
  int unsigned ready_bit  = 0;

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // ---------------------------------------------------------------------------
  // Calendar helpers and predictor
  // ---------------------------------------------------------------------------

  function automatic logic is_leap_year(int unsigned year);
    return (year % 4 == 0) && ((year % 100 != 0) || (year % 400 == 0));
  endfunction

  function automatic int unsigned days_in(int unsigned month, logic leap);
    case (month)
      2: begin
        return leap ? 29 : 28;
      end
      4, 6, 9, 11: begin
        return 30;
      end
      default: begin
        return 31;
      end
    endcase
  endfunction

  // Decode a YYMMDDhhmm stamp into seconds since 1980-01-01; 0 when illegal.
  function automatic logic decode_stamp_seconds(input logic [31:0] stamp,
                                                output logic [31:0] secs);
    int unsigned v, year, month, day, hour, minute, days, y, m;
    logic leap;
    v      = stamp;
    year   = 2000 + v / 100000000;
    month  = (v % 100000000) / 1000000;
    day    = (v % 1000000) / 10000;
    hour   = (v % 10000) / 100;
    minute = v % 100;
    secs   = '0;
    if (month < 1 || month > 12 || hour > 23 || minute > 59) begin
      return 1'b0;
    end
    leap = is_leap_year(year);
    if (day < 1 || day > days_in(month, leap)) begin
      return 1'b0;
    end
    days = 0;
    for (y = 1980; y < year; y++) begin
      days += is_leap_year(y) ? 366 : 365;
    end
    for (m = 1; m < month; m++) begin
      days += days_in(m, leap);
    end
    days += day - 1;
    secs = 32'(days * 86400 + hour * 3600 + minute * 60);
    return 1'b1;
  endfunction

  function automatic span_t predict_difference(stamp_pair_t pair);
    span_t       span;
    logic [31:0] secs_first, secs_second;
    logic        ok_first, ok_second;
    ok_first  = decode_stamp_seconds(pair.first, secs_first);
    ok_second = decode_stamp_seconds(pair.second, secs_second);
    if (ok_first && ok_second) begin
      span.seconds = secs_second - secs_first;
      span.legal   = 1'b1;
    end else begin
      span.seconds = '0;
      span.legal   = 1'b0;
    end
    return span;
  endfunction

  // ---------------------------------------------------------------------------
  // Stimulus helpers
  // ---------------------------------------------------------------------------

  function automatic logic [31:0] pack_stamp(int unsigned yoff, int unsigned month,
                                             int unsigned day, int unsigned hour,
                                             int unsigned minute);
    return 32'(yoff * 100000000 + month * 1000000 + day * 10000 + hour * 100 + minute);
  endfunction

  function automatic logic [31:0] random_legal_stamp();
    int unsigned yoff, month;
    yoff  = $urandom_range(0, 42);
    month = $urandom_range(1, 12);
    return pack_stamp(yoff, month, $urandom_range(1, days_in(month, is_leap_year(2000 + yoff))),
                      $urandom_range(0, 23), $urandom_range(0, 59));
  endfunction

  // Spoil exactly one field; keep the year below 2042 so the value fits 32 bits.
  function automatic logic [31:0] random_broken_stamp();
    int unsigned  yoff, month, day, hour, minute, mlen;
    field_fault_t fault;
    yoff   = $urandom_range(0, 41);
    month  = $urandom_range(1, 12);
    mlen   = days_in(month, is_leap_year(2000 + yoff));
    day    = $urandom_range(1, mlen);
    hour   = $urandom_range(0, 23);
    minute = $urandom_range(0, 59);
    fault  = field_fault_t'($urandom_range(0, 3));
    case (fault)
      BREAK_MONTH: begin
        month = ($urandom_range(0, 1) == 0) ? 0 : $urandom_range(13, 99);
      end
      BREAK_DAY: begin
        day = ($urandom_range(0, 1) == 0) ? 0 : $urandom_range(mlen + 1, 99);
      end
      BREAK_HOUR: begin
        hour = $urandom_range(24, 99);
      end
      default: begin
        minute = $urandom_range(60, 99);
      end
    endcase
    return pack_stamp(yoff, month, day, hour, minute);
  endfunction

  task automatic add_pair(logic [31:0] first, logic [31:0] second);
    stamp_pair_t pair;
    pair.first  = first;
    pair.second = second;
    pending_pairs.push_back(pair);
    total_pairs++;
  endtask

  task automatic report_mismatch(string msg);
    $display("MISMATCH @%0t: %s", $time, msg);
    error_count++;
  endtask

  // ---------------------------------------------------------------------------
  // Driver: feed the input channel from the pending queue in bursts
  // ---------------------------------------------------------------------------

  always @(posedge clk) begin
    stamp_pair_t pair;
    if (rst) begin
      stamps_ch.valid        <= 1'b0;
      stamps_ch.stamp_first  <= '0;
      stamps_ch.stamp_second <= '0;
      burst_left = $urandom_range(1, 24);
      gap_left   = 0;
    end else begin
      // Record the prediction for the pair that transfers on this edge.
      if (stamps_ch.valid && stamps_ch.ready) begin
        pair.first  = stamps_ch.stamp_first;
        pair.second = stamps_ch.stamp_second;
        expected_spans.push_back(predict_difference(pair));
        accepted_pairs++;
      end
      // Hold the payload while it is offered and not yet taken.
      if (!stamps_ch.valid || stamps_ch.ready) begin
        if (gap_left != 0) begin
          gap_left--;
          stamps_ch.valid <= 1'b0;
        end else if (pending_pairs.size() != 0) begin
          pair = pending_pairs.pop_front();
          stamps_ch.stamp_first  <= pair.first;
          stamps_ch.stamp_second <= pair.second;
          stamps_ch.valid        <= 1'b1;
          // Close the burst and pick the next gap; a quarter of gaps are empty.
          if (burst_left > 1) begin
            burst_left--;
          end else begin
            burst_left = $urandom_range(1, 24);
            gap_left   = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
          end
        end else begin
          stamps_ch.valid <= 1'b0;
        end
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Monitor: stall the result channel and check every transfer
  // ---------------------------------------------------------------------------

  always @(posedge clk) begin
    span_t want;
    if (!rst && result_ch.valid && result_ch.ready) begin
      if (expected_spans.size() == 0) begin
        report_mismatch($sformatf("unexpected result %0d legal=%0b",
                                  result_ch.difference_seconds, result_ch.dates_valid));
      end else begin
        want = expected_spans.pop_front();
        if (result_ch.difference_seconds !== want.seconds) begin
          report_mismatch($sformatf("difference_seconds got %0d want %0d",
                                    result_ch.difference_seconds, want.seconds));
        end
        if (result_ch.dates_valid !== want.legal) begin
          report_mismatch($sformatf("dates_valid got %0b want %0b",
                                    result_ch.dates_valid, want.legal));
        end
        checked_spans++;
        if (want.legal) begin
          legal_spans++;
        end
      end
    end
    // Draw a new stall word once the last is used up: free-flowing, half, light or heavy stalls.
    if (ready_bit == 0) begin
      case ($urandom_range(0, 3))
        0: begin
          ready_word = '1;
        end
        1: begin
          ready_word = $urandom;
        end
        2: begin
          ready_word = $urandom | $urandom;
        end
        default: begin
          ready_word = $urandom & $urandom;
        end
      endcase
    end
    result_ch.ready <= ready_word[ready_bit];
    ready_bit = (ready_bit + 1) % 32;
  end

  // ---------------------------------------------------------------------------
  // Stimulus, drain and verdict
  // ---------------------------------------------------------------------------

  initial begin
    int unsigned kind;

    // Directed: field extremes, leap rules, every illegal field, wrap-around.
    add_pair(32'h0000_0000, 32'h0000_0000);
    add_pair(32'hFFFF_FFFF, 32'hFFFF_FFFF);
    add_pair(pack_stamp(0, 1, 1, 0, 0), pack_stamp(42, 12, 31, 23, 59));
    add_pair(pack_stamp(42, 12, 31, 23, 59), pack_stamp(0, 1, 1, 0, 0));
    add_pair(pack_stamp(17, 8, 15, 9, 30), pack_stamp(17, 8, 15, 9, 30));
    add_pair(pack_stamp(0, 2, 29, 12, 0), pack_stamp(0, 3, 1, 0, 0));
    add_pair(pack_stamp(1, 2, 29, 0, 0), pack_stamp(1, 3, 1, 0, 0));
    add_pair(pack_stamp(1, 2, 28, 23, 59), pack_stamp(1, 3, 1, 0, 0));
    add_pair(pack_stamp(40, 2, 29, 6, 45), pack_stamp(41, 2, 28, 6, 45));
    add_pair(pack_stamp(5, 6, 0, 0, 0), pack_stamp(5, 6, 1, 0, 0));
    add_pair(pack_stamp(10, 4, 30, 0, 0), pack_stamp(10, 4, 31, 0, 0));
    add_pair(pack_stamp(10, 1, 32, 0, 0), pack_stamp(10, 1, 31, 0, 0));
    add_pair(pack_stamp(3, 7, 15, 24, 0), pack_stamp(3, 7, 15, 23, 0));
    add_pair(pack_stamp(3, 7, 15, 23, 60), pack_stamp(3, 7, 15, 23, 59));
    add_pair(pack_stamp(3, 13, 1, 0, 0), pack_stamp(3, 12, 1, 0, 0));
    add_pair(pack_stamp(3, 0, 1, 0, 0), pack_stamp(3, 1, 1, 0, 0));
    add_pair(pack_stamp(20, 5, 5, 5, 5), pack_stamp(20, 5, 5, 99, 99));
    add_pair(pack_stamp(39, 12, 31, 23, 59), pack_stamp(40, 1, 1, 0, 0));
    add_pair(pack_stamp(30, 6, 1, 0, 1), pack_stamp(30, 6, 1, 0, 0));
    add_pair(pack_stamp(42, 12, 31, 23, 59), 32'hFFFF_FFFF);
    add_pair(32'h5555_5555, 32'hAAAA_AAAA);

    // Random: mostly legal pairs, mixed with pairs holding one broken field or raw noise.
    repeat (RANDOM_PAIRS) begin
      kind = $urandom_range(0, 99);
      if (kind < 70) begin
        add_pair(random_legal_stamp(), random_legal_stamp());
      end else if (kind < 80) begin
        add_pair(random_broken_stamp(), random_legal_stamp());
      end else if (kind < 88) begin
        add_pair(random_legal_stamp(), random_broken_stamp());
      end else if (kind < 94) begin
        add_pair($urandom, $urandom);
      end else begin
        add_pair(random_legal_stamp(), $urandom);
      end
    end

    repeat (2) @(posedge clk);
    rst <= 1'b0;

    // Wait for every pair to transfer and every answer to come back.
    do begin
      @(negedge clk);
    end while (accepted_pairs != total_pairs || expected_spans.size() != 0);
    repeat (TAIL_CYCLES) @(negedge clk);

    $display("Checked %0d differences from %0d stamp pairs: %0d legal, %0d rejected.",
             checked_spans, total_pairs, legal_spans, checked_spans - legal_spans);
    $display("Mismatches reported: %0d", error_count);
    if (error_count == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

  // Watchdog: far beyond the slowest legal run of this stimulus.
  initial begin
    #2000000;
    $display("Timed out with %0d answers outstanding", expected_spans.size());
    $display("Regression FAIL");
    $finish;
  end

endmodule
